>>> hw/rtl/rmts_pkg.sv
// Shared types and constants for the rate-monotonic tick scheduler.
// Used by rmts_cell and rate_monotonic_tick_scheduler; no dependencies.
package rmts_pkg;

  localparam int NUM_TASKS  = 4;
  localparam int CFG_TASKS  = 4;
  localparam int TIME_BITS  = 16;
  localparam int TASK_IDX_W = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
  localparam int CFG_IDX_W  = $clog2(2 * CFG_TASKS);
  localparam int CFG_DATA_W = 16;
  localparam int RUN_W      = 2;
  localparam int MASK_W     = 4;
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 8;

  // Best candidate seen so far as the search token walks the cell row.
  typedef struct packed {
    logic                  valid;
    logic [TIME_BITS-1:0]  period;
    logic [TASK_IDX_W-1:0] idx;
  } best_t;

  // Per-tick control broadcast to every cell.
  typedef struct packed {
    logic start;    // tick accepted: run the release update
    logic restart;  // clear countdown and pending work first
    logic grant;    // this cell won the tick: burn one unit of work
  } cell_ctl_t;

  // Register writes aimed at one cell.
  typedef struct packed {
    logic                 period_we;
    logic                 wcet_we;
    logic [TIME_BITS-1:0] data;
  } cell_cfg_t;

endpackage

>>> hw/rtl/rmts_cell.sv
// One task slot of the scheduler row: period/wcet registers, release countdown,
// pending work, and one hop of the shortest-period search. Depends on rmts_pkg.
module rmts_cell (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [rmts_pkg::TASK_IDX_W-1:0] cell_idx,
  input  rmts_pkg::cell_cfg_t            cfg,
  input  rmts_pkg::cell_ctl_t            ctl,
  input  logic                           token_in,
  input  rmts_pkg::best_t                best_in,
  output logic                           token_out,
  output rmts_pkg::best_t                best_out,
  output logic                           missed
);

  logic [rmts_pkg::TIME_BITS-1:0] period_r, wcet_r;
  logic [rmts_pkg::TIME_BITS-1:0] ttr_r, ttr_nxt;
  logic [rmts_pkg::TIME_BITS-1:0] work_r, work_nxt;
  logic [rmts_pkg::TIME_BITS-1:0] ttr_cur, work_cur;
  logic                           missed_r, missed_nxt;
  logic                           token_r;
  rmts_pkg::best_t                best_r, best_nxt;
  logic                           eligible;

  assign ttr_cur  = ctl.restart ? '0 : ttr_r;
  assign work_cur = ctl.restart ? '0 : work_r;

  always_comb begin
    ttr_nxt    = ttr_r;
    work_nxt   = work_r;
    missed_nxt = missed_r;
    if (ctl.start) begin
      missed_nxt = 1'b0;
      if (period_r == '0) begin
        ttr_nxt  = '0;
        work_nxt = '0;
      end else if (ttr_cur == '0) begin
        ttr_nxt = period_r - 1'b1;
        if (work_cur != '0) begin
          missed_nxt = 1'b1;
          work_nxt   = work_cur;
        end else begin
          work_nxt = wcet_r;
        end
      end else begin
        ttr_nxt  = ttr_cur - 1'b1;
        work_nxt = work_cur;
      end
    end else if (ctl.grant) begin
      work_nxt = work_r - 1'b1;
    end
  end

  // Take over the candidate when ready and strictly shorter; ties keep the earlier cell.
  assign eligible = (period_r != '0) && (work_r != '0) &&
                    (!best_in.valid || (period_r < best_in.period));

  always_comb begin
    best_nxt = best_r;
    if (token_in) begin
      if (eligible) begin
        best_nxt.valid  = 1'b1;
        best_nxt.period = period_r;
        best_nxt.idx    = cell_idx;
      end else begin
        best_nxt = best_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= '0;
      wcet_r   <= '0;
      ttr_r    <= '0;
      work_r   <= '0;
      missed_r <= 1'b0;
      token_r  <= 1'b0;
    end else begin
      if (cfg.period_we) period_r <= cfg.data;
      if (cfg.wcet_we)   wcet_r   <= cfg.data;
      ttr_r    <= ttr_nxt;
      work_r   <= work_nxt;
      missed_r <= missed_nxt;
      token_r  <= token_in;
    end
  end

  always_ff @(posedge clk) begin
    best_r <= best_nxt;
  end

  assign token_out = token_r;
  assign best_out  = best_r;
  assign missed    = missed_r;

endmodule

>>> hw/rtl/rate_monotonic_tick_scheduler.sv
// Rate-monotonic tick scheduler: each input beat is one scheduler tick; each tick
// yields one output beat naming the granted task and the tasks that overran.
// Depends on rmts_pkg and rmts_cell.
//
// Every task lives in its own cell of a row. On the accepted beat all cells run
// their release step in parallel: a countdown that reaches zero reloads with
// period-1 and loads the task's worst-case work, or flags a miss when work is
// still pending. A search token then walks the row one cell per cycle, carrying
// the ready task with the shortest period (ties to the lower index). When it
// leaves the last cell and no earlier result is unclaimed, the winner's work
// drops by one and the result beat is loaded into the output register. A tick
// keeps the block busy until that grant; a result waiting on out_tready does
// not block the next input beat, only the grant of that next tick. A period of
// zero disables a task. Restart in the input beat clears all countdowns and
// pending work before that tick.
// Configuration: write cfg_wdata to register cfg_index while cfg_we is high
// (0..3 periods, 4..7 worst-case times); write only while the block is idle.
module rate_monotonic_tick_scheduler (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [rmts_pkg::IN_DATA_W-1:0]  in_tdata,   // [0] restart, [7:1] zero
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [rmts_pkg::OUT_DATA_W-1:0] out_tdata,  // [1:0] run_task, [2] idle,
                                                      // [6:3] missed_mask, [7] zero
  input  logic                            cfg_we,
  input  logic [rmts_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rmts_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int N = rmts_pkg::NUM_TASKS;

  logic                            busy_r, start_r, done_r, out_valid_r;
  logic [rmts_pkg::OUT_DATA_W-1:0] out_data_r;
  logic                            in_accept, search_end, grant_fire;
  logic [N:0]                      token;
  rmts_pkg::best_t                 best [N+1];
  logic [N-1:0]                    missed_vec;
  logic [rmts_pkg::RUN_W-1:0]      run_task;
  logic                            idle;
  logic [rmts_pkg::MASK_W-1:0]     missed_mask;

  assign in_tready  = !busy_r;
  assign in_accept  = in_tvalid && in_tready;
  assign search_end = token[N] || done_r;
  // Hold the grant while an earlier result still sits unclaimed.
  assign grant_fire = search_end && (!out_valid_r || out_tready);

  assign token[0] = start_r;
  assign best[0]  = '0;

  for (genvar t = 0; t < N; t++) begin : g_cell
    rmts_pkg::cell_cfg_t cfg_t;
    rmts_pkg::cell_ctl_t ctl_t;

    assign cfg_t.period_we = cfg_we && (t < rmts_pkg::CFG_TASKS) &&
                             (cfg_index == rmts_pkg::CFG_IDX_W'(t));
    assign cfg_t.wcet_we   = cfg_we && (t < rmts_pkg::CFG_TASKS) &&
                             (cfg_index == rmts_pkg::CFG_IDX_W'(rmts_pkg::CFG_TASKS + t));
    assign cfg_t.data      = rmts_pkg::TIME_BITS'(cfg_wdata);

    assign ctl_t.start   = in_accept;
    assign ctl_t.restart = in_tdata[0];
    assign ctl_t.grant   = grant_fire && best[N].valid &&
                           (best[N].idx == rmts_pkg::TASK_IDX_W'(t));

    rmts_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cell_idx  (rmts_pkg::TASK_IDX_W'(t)),
      .cfg       (cfg_t),
      .ctl       (ctl_t),
      .token_in  (token[t]),
      .best_in   (best[t]),
      .token_out (token[t+1]),
      .best_out  (best[t+1]),
      .missed    (missed_vec[t])
    );
  end

  assign run_task    = best[N].valid ? rmts_pkg::RUN_W'(best[N].idx) : '0;
  assign idle        = !best[N].valid;
  assign missed_mask = rmts_pkg::MASK_W'(missed_vec);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      start_r     <= 1'b0;
      done_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      start_r <= in_accept;
      // Busy from the accepted beat until the grant retires the tick.
      if (in_accept) begin
        busy_r <= 1'b1;
      end else if (grant_fire) begin
        busy_r <= 1'b0;
      end
      done_r <= search_end && !grant_fire;
      if (grant_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (grant_fire) begin
      out_data_r <= rmts_pkg::OUT_DATA_W'({missed_mask, idle, run_task});
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // At most one search token in flight along the row.
  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(token))
    else $error("more than one search token in the cell row");

  // A token only walks the row while a tick is in progress.
  a_token_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (token != '0) |-> busy_r)
    else $error("search token seen while idle");

  // A grant always presents a result beat on the next cycle.
  a_grant_out: assert property (@(posedge clk) disable iff (!rst_n)
    grant_fire |=> out_valid_r)
    else $error("grant did not load the output register");

  // No new tick is taken before the current one is granted.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> !in_tready)
    else $error("input accepted while a tick was in progress");

endmodule
